// ----- sv/dtq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int DL_W  = 48;
  localparam int IVL_W = 32;
  localparam int ID_W  = 32;
  localparam int AGE_W = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // one stored timer
  typedef struct packed {
    logic [DL_W-1:0]  deadline;
    logic [IVL_W-1:0] interval;
    logic [ID_W-1:0]  ident;
    logic [AGE_W-1:0] age;
  } slot_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

endpackage

// ----- sv/deadline_timer_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Earliest-deadline timer table: add, remove by id, and tick that fires the
// earliest due timer and re-arms repeating ones.
// ----------------------------------------------------------------------------
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+---------------------------
//  command   | in_kind, in_time_value, in_repeat_...  | taken when start && !busy
//  result    | out_assigned_id .. out_next_deadline   | out_valid, one cycle, no stall
//
//  An item passes through SCAN1, ACT, SCAN2 and FIN to its result strobe: two
//  scans over the slot memory, one slot per cycle through its single read port
//  and the shared compare unit, each running on past the last slot to cover the
//  registered read data, with an update step between them and a result step last.
//  Busy drops in the cycle the result strobe shows; a new item may be taken then.
//  Reset clears all slot valid bits and both counters at once; no clearing pass.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_time_value,
  input  logic [31:0] in_repeat_interval,
  input  logic [31:0] in_timer_id,
  input  logic        in_handler_stop,
  output logic        out_valid,
  output logic [31:0] out_assigned_id,
  output logic        out_table_full,
  output logic        out_fired,
  output logic [31:0] out_fired_id,
  output logic        out_armed,
  output logic [47:0] out_next_deadline
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(TIMER_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN1 = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_SCAN2 = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0]            last_id_r, last_id_nxt;
  logic [31:0]            ins_ctr_r, ins_ctr_nxt;

  logic [1:0]             kind_r, kind_nxt;
  logic [47:0]            tval_r, tval_nxt;
  logic [31:0]            ival_r, ival_nxt;
  logic [31:0]            rid_r, rid_nxt;
  logic                   stop_r, stop_nxt;

  logic                   free_found_r, free_found_nxt;
  logic [IW-1:0]          free_idx_r, free_idx_nxt;

  logic                   ov_r, ov_nxt;
  logic [31:0]            assigned_r, assigned_nxt;
  logic                   full_r, full_nxt;
  logic                   fired_r, fired_nxt;
  logic [31:0]            fid_r, fid_nxt;
  logic                   armed_r, armed_nxt;
  logic [47:0]            nd_r, nd_nxt;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  dtq_pkg::slot_t         mem_wdata;
  dtq_pkg::slot_t         mem_rdata;
  logic [IW-1:0]          rd_addr;

  dtq_pkg::scan_ctl_t     scan_ctl;
  logic                   best_found;
  dtq_pkg::slot_t         best;
  logic [IW-1:0]          best_idx;

  logic [CW-1:0]          cnt_m1;
  logic [IW-1:0]          ev_idx;
  logic                   ev_on;
  logic [48:0]            rearm_sum;
  logic [47:0]            rearm_dl;

  assign rd_addr = cnt_r[IW-1:0];
  assign cnt_m1  = cnt_r - CW'(1);
  assign ev_idx  = cnt_m1[IW-1:0];
  // slot cnt-1 has its read data ready this cycle
  assign ev_on   = (cnt_r != '0);

  assign rearm_sum = {1'b0, tval_r} + {17'b0, best.interval};
  assign rearm_dl  = rearm_sum[48] ? '1 : rearm_sum[47:0];

  dtq_slot_mem #(
    .DEPTH (TIMER_SLOTS),
    .IW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  dtq_min_unit #(
    .IW (IW)
  ) u_min (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .cand       (mem_rdata),
    .cand_idx   (ev_idx),
    .best_found (best_found),
    .best       (best),
    .best_idx   (best_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    last_id_nxt    = last_id_r;
    ins_ctr_nxt    = ins_ctr_r;
    kind_nxt       = kind_r;
    tval_nxt       = tval_r;
    ival_nxt       = ival_r;
    rid_nxt        = rid_r;
    stop_nxt       = stop_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    ov_nxt         = 1'b0;
    assigned_nxt   = assigned_r;
    full_nxt       = full_r;
    fired_nxt      = fired_r;
    fid_nxt        = fid_r;
    armed_nxt      = armed_r;
    nd_nxt         = nd_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    mem_wdata      = '{deadline: tval_r, interval: ival_r,
                       ident: last_id_r + 32'd1, age: ins_ctr_r};
    scan_ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt       = in_kind;
          tval_nxt       = in_time_value;
          ival_nxt       = in_repeat_interval;
          rid_nxt        = in_timer_id;
          stop_nxt       = in_handler_stop;
          free_found_nxt = 1'b0;
          assigned_nxt   = '0;
          full_nxt       = 1'b0;
          fired_nxt      = 1'b0;
          fid_nxt        = '0;
          cnt_nxt        = '0;
          scan_ctl.clr   = 1'b1;
          state_nxt      = ST_SCAN1;
        end
      end
      ST_SCAN1: begin
        cnt_nxt = cnt_r + CW'(1);
        if (ev_on) begin
          priority if (kind_r == dtq_pkg::KIND_ADD) begin
            if (!valid_r[ev_idx] && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = ev_idx;
            end
          end else if (kind_r == dtq_pkg::KIND_REMOVE) begin
            if (valid_r[ev_idx] && (mem_rdata.ident == rid_r)) begin
              valid_nxt[ev_idx] = 1'b0;
            end
          end else if (kind_r == dtq_pkg::KIND_TICK) begin
            scan_ctl.en = valid_r[ev_idx];
          end else begin
          end
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (kind_r == dtq_pkg::KIND_ADD) begin
          if (free_found_r) begin
            mem_we                = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            last_id_nxt           = last_id_r + 32'd1;
            ins_ctr_nxt           = ins_ctr_r + 32'd1;
            assigned_nxt          = last_id_r + 32'd1;
          end else begin
            full_nxt = 1'b1;
          end
        end else if (kind_r == dtq_pkg::KIND_TICK) begin
          if (best_found && (best.deadline <= tval_r)) begin
            fired_nxt = 1'b1;
            fid_nxt   = best.ident;
            if ((best.interval == '0) || stop_r) begin
              valid_nxt[best_idx] = 1'b0;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = best_idx;
              mem_wdata   = '{deadline: rearm_dl, interval: best.interval,
                              ident: best.ident, age: ins_ctr_r};
              ins_ctr_nxt = ins_ctr_r + 32'd1;
            end
          end
        end
        scan_ctl.clr = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_SCAN2;
      end
      ST_SCAN2: begin
        cnt_nxt     = cnt_r + CW'(1);
        scan_ctl.en = ev_on && valid_r[ev_idx];
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ov_nxt    = 1'b1;
        armed_nxt = best_found;
        nd_nxt    = best_found ? best.deadline : '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      valid_r   <= '0;
      last_id_r <= '0;
      ins_ctr_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      valid_r   <= valid_nxt;
      last_id_r <= last_id_nxt;
      ins_ctr_r <= ins_ctr_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tval_r       <= tval_nxt;
    ival_r       <= ival_nxt;
    rid_r        <= rid_nxt;
    stop_r       <= stop_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    assigned_r   <= assigned_nxt;
    full_r       <= full_nxt;
    fired_r      <= fired_nxt;
    fid_r        <= fid_nxt;
    armed_r      <= armed_nxt;
    nd_r         <= nd_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = ov_r;
  assign out_assigned_id   = assigned_r;
  assign out_table_full    = full_r;
  assign out_fired         = fired_r;
  assign out_fired_id      = fid_r;
  assign out_armed         = armed_r;
  assign out_next_deadline = nd_r;

  a_result_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe right after accept");

  a_fire_excludes_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (out_assigned_id == '0) && !out_table_full)
    else $error("fire reported together with add fields");

  a_idle_deadline_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_armed) |-> (out_next_deadline == '0))
    else $error("deadline reported with nothing armed");

  a_add_grows_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACT && kind_r == dtq_pkg::KIND_ADD && free_found_r) |=>
      ($countones(valid_r) == $countones($past(valid_r)) + 1))
    else $error("add did not occupy exactly one slot");

endmodule

// ----- sv/dtq_slot_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_slot_mem
// Timer slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dtq_slot_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  dtq_pkg::slot_t       wdata,
  input  logic [IW-1:0]        raddr,
  output dtq_pkg::slot_t       rdata
);

  dtq_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/dtq_min_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_min_unit
// Shared compare unit: tracks the earliest (deadline, age) slot seen in a scan.
// ----------------------------------------------------------------------------
module dtq_min_unit #(
  parameter int IW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtq_pkg::scan_ctl_t   ctl,
  input  dtq_pkg::slot_t       cand,
  input  logic [IW-1:0]        cand_idx,
  output logic                 best_found,
  output dtq_pkg::slot_t       best,
  output logic [IW-1:0]        best_idx
);

  logic           found_r, found_nxt;
  dtq_pkg::slot_t best_r, best_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic           better;

  // strict compare keeps the earlier slot on a full tie
  assign better = !found_r ||
                  (cand.deadline < best_r.deadline) ||
                  ((cand.deadline == best_r.deadline) && (cand.age < best_r.age));

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (ctl.en && better) begin
      found_nxt = 1'b1;
      best_nxt  = cand;
      idx_nxt   = cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    idx_r  <= idx_nxt;
  end

  assign best_found = found_r;
  assign best       = best_r;
  assign best_idx   = idx_r;

endmodule

// ----- test/deadline_timer_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_tb
// Self-checking bench for the earliest-deadline timer table. A short directed
// table covers the extreme fields, every command, the full table, tie order,
// stop requests and re-arm saturation. Random add/remove/tick traffic, with some
// unused commands and random sender gaps or bursts, follows. Results are checked
// against a local model of the timer table or fixed directed expectations.
// ----------------------------------------------------------------------------
module deadline_timer_queue_tb;

  localparam int SLOTS        = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [dtq_pkg::DL_W-1:0]  DL_MAX  = '1;
  localparam logic [dtq_pkg::IVL_W-1:0] IVL_MAX = '1;

  typedef struct packed {
    logic [dtq_pkg::ID_W-1:0] assigned_id;
    logic                     table_full;
    logic                     fired;
    logic [dtq_pkg::ID_W-1:0] fired_id;
    logic                     armed;
    logic [dtq_pkg::DL_W-1:0] next_deadline;
  } timer_result_t;

  typedef struct {
    logic [1:0]                kind;
    logic [dtq_pkg::DL_W-1:0]  tval;
    logic [dtq_pkg::IVL_W-1:0] ival;
    logic [dtq_pkg::ID_W-1:0]  rid;
    logic                      stop;
    bit                        typed;
    timer_result_t             want;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_kind;
  logic [dtq_pkg::DL_W-1:0]  in_time_value;
  logic [dtq_pkg::IVL_W-1:0] in_repeat_interval;
  logic [dtq_pkg::ID_W-1:0]  in_timer_id;
  logic                      in_handler_stop;
  logic                      out_valid;
  logic [dtq_pkg::ID_W-1:0]  out_assigned_id;
  logic                      out_table_full;
  logic                      out_fired;
  logic [dtq_pkg::ID_W-1:0]  out_fired_id;
  logic                      out_armed;
  logic [dtq_pkg::DL_W-1:0]  out_next_deadline;

  deadline_timer_queue #(
    .TIMER_SLOTS(SLOTS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_time_value     (in_time_value),
    .in_repeat_interval(in_repeat_interval),
    .in_timer_id       (in_timer_id),
    .in_handler_stop   (in_handler_stop),
    .out_valid         (out_valid),
    .out_assigned_id   (out_assigned_id),
    .out_table_full    (out_table_full),
    .out_fired         (out_fired),
    .out_fired_id      (out_fired_id),
    .out_armed         (out_armed),
    .out_next_deadline (out_next_deadline)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // local copy of the timer table
  bit                        tq_valid    [SLOTS];
  logic [dtq_pkg::DL_W-1:0]  tq_deadline [SLOTS];
  logic [dtq_pkg::IVL_W-1:0] tq_interval [SLOTS];
  logic [dtq_pkg::ID_W-1:0]  tq_ident    [SLOTS];
  logic [dtq_pkg::AGE_W-1:0] tq_age      [SLOTS];
  logic [dtq_pkg::ID_W-1:0]  tq_last_id  = '0;
  logic [dtq_pkg::AGE_W-1:0] tq_age_ctr  = '0;

  timer_result_t            pending_results[$];
  stim_row_t                directed_rows[$];
  logic [dtq_pkg::ID_W-1:0] live_ids[$];
  timer_result_t            oldest;

  int mismatches   = 0;
  int stall_cycles = 0;
  int n_add = 0, n_remove = 0, n_tick = 0, n_other = 0;
  int n_fired = 0, n_full = 0;

  // earliest pending timer, oldest insert on ties; -1 when nothing is armed
  function automatic int earliest_timer();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tq_valid[i] && (best < 0 || tq_deadline[i] < tq_deadline[best] ||
          (tq_deadline[i] == tq_deadline[best] && tq_age[i] < tq_age[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic timer_result_t apply_timer_cmd(logic [1:0] kind,
      logic [dtq_pkg::DL_W-1:0] tval, logic [dtq_pkg::IVL_W-1:0] ival,
      logic [dtq_pkg::ID_W-1:0] rid, logic stop);
    timer_result_t          r;
    int                     slot;
    logic [dtq_pkg::DL_W:0] rearm;
    r = '0;
    case (kind)
      dtq_pkg::KIND_ADD: begin
        slot = -1;
        for (int i = 0; i < SLOTS; i++)
          if (!tq_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          tq_last_id        = tq_last_id + 1'b1;
          tq_valid[slot]    = 1'b1;
          tq_deadline[slot] = tval;
          tq_interval[slot] = ival;
          tq_ident[slot]    = tq_last_id;
          tq_age[slot]      = tq_age_ctr;
          tq_age_ctr        = tq_age_ctr + 1'b1;
          r.assigned_id     = tq_last_id;
        end
      end
      dtq_pkg::KIND_REMOVE: begin
        for (int i = 0; i < SLOTS; i++)
          if (tq_valid[i] && tq_ident[i] == rid) tq_valid[i] = 1'b0;
      end
      dtq_pkg::KIND_TICK: begin
        slot = earliest_timer();
        if (slot >= 0 && tq_deadline[slot] <= tval) begin
          r.fired    = 1'b1;
          r.fired_id = tq_ident[slot];
          if (tq_interval[slot] == '0 || stop) begin
            tq_valid[slot] = 1'b0;
          end else begin
            rearm = {1'b0, tval} + (dtq_pkg::DL_W + 1)'(tq_interval[slot]);
            tq_deadline[slot] = rearm[dtq_pkg::DL_W] ? DL_MAX : rearm[dtq_pkg::DL_W-1:0];
            tq_age[slot]      = tq_age_ctr;
            tq_age_ctr        = tq_age_ctr + 1'b1;
          end
        end
      end
      default: ;
    endcase
    slot = earliest_timer();
    r.armed         = (slot >= 0);
    r.next_deadline = (slot >= 0) ? tq_deadline[slot] : '0;
    return r;
  endfunction

  function automatic timer_result_t typed_result(logic [dtq_pkg::ID_W-1:0] aid,
      logic full, logic fired, logic [dtq_pkg::ID_W-1:0] fid, logic armed,
      logic [dtq_pkg::DL_W-1:0] nd);
    timer_result_t r;
    r = '{assigned_id: aid, table_full: full, fired: fired, fired_id: fid,
          armed: armed, next_deadline: nd};
    return r;
  endfunction

  // present one item at a falling edge and hold it until the block takes it
  task automatic send_command(logic [1:0] kind, logic [dtq_pkg::DL_W-1:0] tval,
      logic [dtq_pkg::IVL_W-1:0] ival, logic [dtq_pkg::ID_W-1:0] rid, logic stop,
      int gap, bit typed, timer_result_t want);
    timer_result_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start              = 1'b1;
    in_kind            = kind;
    in_time_value      = tval;
    in_repeat_interval = ival;
    in_timer_id        = rid;
    in_handler_stop    = stop;
    do @(posedge clk); while (busy);
    predicted = apply_timer_cmd(kind, tval, ival, rid, stop);
    pending_results.push_back(typed ? want : predicted);
    case (kind)
      dtq_pkg::KIND_ADD:    n_add++;
      dtq_pkg::KIND_REMOVE: n_remove++;
      dtq_pkg::KIND_TICK:   n_tick++;
      default:              n_other++;
    endcase
    if (predicted.fired) n_fired++;
    if (predicted.table_full) n_full++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_assigned_id !== oldest.assigned_id) begin
          $error("assigned_id: expected %0d, got %0d", oldest.assigned_id, out_assigned_id);
          mismatches++;
        end
        if (out_table_full !== oldest.table_full) begin
          $error("table_full: expected %0b, got %0b", oldest.table_full, out_table_full);
          mismatches++;
        end
        if (out_fired !== oldest.fired) begin
          $error("fired: expected %0b, got %0b", oldest.fired, out_fired);
          mismatches++;
        end
        if (out_fired_id !== oldest.fired_id) begin
          $error("fired_id: expected %0d, got %0d", oldest.fired_id, out_fired_id);
          mismatches++;
        end
        if (out_armed !== oldest.armed) begin
          $error("armed: expected %0b, got %0b", oldest.armed, out_armed);
          mismatches++;
        end
        if (out_next_deadline !== oldest.next_deadline) begin
          $error("next_deadline: expected %0h, got %0h",
                 oldest.next_deadline, out_next_deadline);
          mismatches++;
        end
      end
    end
  end

  // watchdog: cycles in which neither an item nor a result is taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    timer_result_t             none;
    logic [1:0]                kind;
    logic [dtq_pkg::DL_W-1:0]  tval;
    logic [dtq_pkg::IVL_W-1:0] ival;
    logic [dtq_pkg::ID_W-1:0]  rid;
    logic [dtq_pkg::DL_W-1:0]  clock_ms;
    logic                      stop;
    int                        pick;
    int                        gap;
    int                        taken;
    bit                        burst;
    bit                        paused;

    none               = '0;
    start              = 1'b0;
    rst_n              = 1'b0;
    in_kind            = dtq_pkg::KIND_ADD;
    in_time_value      = '0;
    in_repeat_interval = '0;
    in_timer_id        = '0;
    in_handler_stop    = 1'b0;
    for (int i = 0; i < SLOTS; i++) tq_valid[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table: nothing fires, unknown remove, unused command
    directed_rows.push_back('{dtq_pkg::KIND_TICK, '0, '0, '0, 1'b0, 1'b1, none});
    directed_rows.push_back('{dtq_pkg::KIND_REMOVE, '0, '0, 32'd5, 1'b0, 1'b1, none});
    directed_rows.push_back('{KIND_UNUSED, DL_MAX, IVL_MAX, '1, 1'b1, 1'b1, none});
    // extreme deadlines and intervals
    directed_rows.push_back('{dtq_pkg::KIND_ADD, DL_MAX, '0, '0, 1'b0, 1'b1,
                              typed_result(32'd1, 1'b0, 1'b0, '0, 1'b1, DL_MAX)});
    directed_rows.push_back('{dtq_pkg::KIND_ADD, '0, IVL_MAX, '0, 1'b0, 1'b1,
                              typed_result(32'd2, 1'b0, 1'b0, '0, 1'b1, '0)});
    directed_rows.push_back('{dtq_pkg::KIND_TICK, '0, '0, '0, 1'b0, 1'b1,
                              typed_result('0, 1'b0, 1'b1, 32'd2, 1'b1, 48'hFFFF_FFFF)});
    // stop request on a repeating timer drops it
    directed_rows.push_back('{dtq_pkg::KIND_TICK, DL_MAX, '0, '0, 1'b1, 1'b1,
                              typed_result('0, 1'b0, 1'b1, 32'd2, 1'b1, DL_MAX)});
    // fill the table with equal deadlines to exercise the tie order
    for (int i = 0; i < SLOTS - 1; i++)
      directed_rows.push_back('{dtq_pkg::KIND_ADD, 48'd100, 32'd10, '0, 1'b0, 1'b0, none});
    directed_rows.push_back('{dtq_pkg::KIND_ADD, 48'd7, 32'd7, '0, 1'b0, 1'b1,
                              typed_result('0, 1'b1, 1'b0, '0, 1'b1, 48'd100)});
    directed_rows.push_back('{dtq_pkg::KIND_TICK, 48'd100, '0, '0, 1'b0, 1'b0, none});
    // re-arm past the top of the time range saturates
    directed_rows.push_back('{dtq_pkg::KIND_TICK, DL_MAX - 48'd3, '0, '0, 1'b0, 1'b0, none});
    directed_rows.push_back('{dtq_pkg::KIND_REMOVE, '0, '0, 32'd1, 1'b0, 1'b0, none});

    foreach (directed_rows[i])
      send_command(directed_rows[i].kind, directed_rows[i].tval, directed_rows[i].ival,
                   directed_rows[i].rid, directed_rows[i].stop, $urandom_range(0, 14),
                   directed_rows[i].typed, directed_rows[i].want);

    clock_ms = '0;
    taken    = 0;
    burst    = 1'b0;
    paused   = 1'b0;
    while (taken < RANDOM_ITEMS) begin
      if (taken % 64 == 0) burst = ($urandom_range(0, 2) == 0);
      if (!paused && taken >= RANDOM_ITEMS / 2) begin
        // hold off until the block has answered everything
        paused = 1'b1;
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      tval = dtq_pkg::DL_W'({$urandom, $urandom});
      ival = $urandom;
      rid  = $urandom;
      stop = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        kind = dtq_pkg::KIND_ADD;
        if ($urandom_range(0, 15) != 0)
          tval = clock_ms + dtq_pkg::DL_W'($urandom_range(0, 200));
        if ($urandom_range(0, 9) != 0)
          ival = ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(1, 50);
      end else if (pick < 55) begin
        kind = dtq_pkg::KIND_REMOVE;
        live_ids.delete();
        for (int i = 0; i < SLOTS; i++)
          if (tq_valid[i]) live_ids.push_back(tq_ident[i]);
        if (live_ids.size() != 0 && $urandom_range(0, 4) != 0)
          rid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      end else if (pick < 95) begin
        kind = dtq_pkg::KIND_TICK;
        if ($urandom_range(0, 15) != 0) begin
          clock_ms = clock_ms + dtq_pkg::DL_W'($urandom_range(0, 40));
          tval     = clock_ms;
        end
      end else begin
        kind = KIND_UNUSED;
      end
      gap = burst ? 0 : $urandom_range(0, 14);
      send_command(kind, tval, ival, rid, stop, gap, 1'b0, none);
      if (kind != KIND_UNUSED) taken++;
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d adds, %0d removes, %0d ticks and %0d no-op commands.",
             n_add, n_remove, n_tick, n_other);
    $display("Saw %0d timer fires and %0d adds rejected on a full table.", n_fired, n_full);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
